// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the cubic interpolator.
// Included by files that check their own control logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst_n, pre, post, msg)
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ----- rtl/mnc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Shared types, fixed-point constants and coefficient functions for the cubic interpolator.
// No dependencies; imported by every module of the block.
package mnc_pkg;

    // Shape registers: Q1.15, 32768 = 1.0
    localparam int SHAPE_W     = 16;
    localparam int SHAPE_ONE   = 32768;
    localparam int SHAPE_RESET = 10923;

    localparam int CFG_INDEX_W = 4;
    localparam logic [CFG_INDEX_W-1:0] REG_SHAPE_B = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_SHAPE_C = CFG_INDEX_W'(1);

    // Internal scale of kernel arithmetic is 2^HP
    localparam int HP     = 24;
    localparam int UP_SH  = HP - 15;
    localparam int RAW_W  = 24;
    localparam int COEF_W = 32;
    localparam int ACC_W  = 34;
    localparam int WGT_W  = 32;

    // Register stages from the input register to the kernel weight
    localparam int TAP_LAT = 10;

    // Kernel coefficients times 6
    localparam int K3_ONE = 12;
    localparam int K3_B   = 9;
    localparam int K3_C   = 6;
    localparam int K2_ONE = -18;
    localparam int K2_B   = 12;
    localparam int K2_C   = 6;
    localparam int K0_ONE = 6;
    localparam int K0_B   = 2;
    localparam int L3_B   = 1;
    localparam int L3_C   = 6;
    localparam int L2_B   = 6;
    localparam int L2_C   = 30;
    localparam int L1_B   = 12;
    localparam int L1_C   = 48;
    localparam int L0_B   = 8;
    localparam int L0_C   = 24;

    typedef struct packed {
        logic                 valid;
        logic [CFG_INDEX_W-1:0] index;
        logic [SHAPE_W-1:0]   data;
    } cfg_wr_t;

    // Horner coefficients, highest power first, scale 2^HP
    typedef struct packed {
        logic signed [COEF_W-1:0] c0;
        logic signed [COEF_W-1:0] c1;
        logic signed [COEF_W-1:0] c2;
        logic signed [COEF_W-1:0] c3;
    } poly_t;

    function automatic logic [SHAPE_W-1:0] clamp_shape(input logic [SHAPE_W-1:0] v);
        return (v > SHAPE_W'(SHAPE_ONE)) ? SHAPE_W'(SHAPE_ONE) : v;
    endfunction

    function automatic logic signed [COEF_W-1:0] scale_up(input logic signed [RAW_W-1:0] raw);
        return COEF_W'(raw) <<< UP_SH;
    endfunction

    // |x| < 1: (12-9B-6C)x^3 + (-18+12B+6C)x^2 + (6-2B)
    function automatic poly_t inner_poly(input logic [SHAPE_W-1:0] b,
                                         input logic [SHAPE_W-1:0] c);
        logic signed [RAW_W-1:0] bs;
        logic signed [RAW_W-1:0] cs;
        poly_t p;
        bs = signed'(RAW_W'(b));
        cs = signed'(RAW_W'(c));
        p.c0 = scale_up(RAW_W'(K3_ONE * SHAPE_ONE) - RAW_W'(K3_B) * bs - RAW_W'(K3_C) * cs);
        p.c1 = scale_up(RAW_W'(K2_ONE * SHAPE_ONE) + RAW_W'(K2_B) * bs + RAW_W'(K2_C) * cs);
        p.c2 = '0;
        p.c3 = scale_up(RAW_W'(K0_ONE * SHAPE_ONE) - RAW_W'(K0_B) * bs);
        return p;
    endfunction

    // 1 <= |x| <= 2: (-B-6C)x^3 + (6B+30C)x^2 + (-12B-48C)x + (8B+24C)
    function automatic poly_t outer_poly(input logic [SHAPE_W-1:0] b,
                                         input logic [SHAPE_W-1:0] c);
        logic signed [RAW_W-1:0] bs;
        logic signed [RAW_W-1:0] cs;
        poly_t p;
        bs = signed'(RAW_W'(b));
        cs = signed'(RAW_W'(c));
        p.c0 = scale_up(-(RAW_W'(L3_B) * bs) - RAW_W'(L3_C) * cs);
        p.c1 = scale_up(RAW_W'(L2_B) * bs + RAW_W'(L2_C) * cs);
        p.c2 = scale_up(-(RAW_W'(L1_B) * bs) - RAW_W'(L1_C) * cs);
        p.c3 = scale_up(RAW_W'(L0_B) * bs + RAW_W'(L0_C) * cs);
        return p;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/mnc_coef.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Shape registers and derived inner/outer kernel coefficients.
// Depends on mnc_pkg.
module mnc_coef (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire mnc_pkg::cfg_wr_t cfg,
    output mnc_pkg::poly_t      inner,
    output mnc_pkg::poly_t      outer
);
    import mnc_pkg::*;

    logic [SHAPE_W-1:0] shape_b_reg;
    logic [SHAPE_W-1:0] shape_b_next;
    logic [SHAPE_W-1:0] shape_c_reg;
    logic [SHAPE_W-1:0] shape_c_next;
    poly_t              inner_reg;
    poly_t              inner_next;
    poly_t              outer_reg;
    poly_t              outer_next;

    always_comb
    begin
        shape_b_next = shape_b_reg;
        shape_c_next = shape_c_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_SHAPE_B: shape_b_next = cfg.data;
                REG_SHAPE_C: shape_c_next = cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        inner_next = inner_poly(clamp_shape(shape_b_reg), clamp_shape(shape_c_reg));
        outer_next = outer_poly(clamp_shape(shape_b_reg), clamp_shape(shape_c_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_b_reg <= SHAPE_W'(SHAPE_RESET);
            shape_c_reg <= SHAPE_W'(SHAPE_RESET);
            inner_reg   <= inner_poly(SHAPE_W'(SHAPE_RESET), SHAPE_W'(SHAPE_RESET));
            outer_reg   <= outer_poly(SHAPE_W'(SHAPE_RESET), SHAPE_W'(SHAPE_RESET));
        end
        else
        begin
            shape_b_reg <= shape_b_next;
            shape_c_reg <= shape_c_next;
            inner_reg   <= inner_next;
            outer_reg   <= outer_next;
        end
    end

    assign inner = inner_reg;
    assign outer = outer_reg;

endmodule
`default_nettype wire

// ----- rtl/mnc_div6.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Four-stage exact round-half-up division by 6 of the Horner result.
// Depends on mnc_pkg.
module mnc_div6 (
    input  wire logic                             clk,
    input  wire logic                             en,
    input  wire logic signed [mnc_pkg::ACC_W-1:0] acc,
    output logic signed [mnc_pkg::WGT_W-1:0]      weight
);
    import mnc_pkg::*;

    localparam int MOFS_W   = ACC_W + 1;
    localparam int SPLIT    = 18;
    localparam int HI_W     = MOFS_W - SPLIT;
    localparam int HSUM_W   = SPLIT + 1;
    localparam int Q_W      = HSUM_W - 1;
    localparam int PH_W     = 2 * HI_W;
    localparam int WS_W     = PH_W + 1;
    localparam int RECIP_SH = 21;
    localparam int RECIP_W  = 20;
    localparam logic [HI_W-1:0]    THIRD_HI = HI_W'(((1 << SPLIT) - 1) / 3);
    localparam logic [RECIP_W-1:0] RECIP3   = RECIP_W'(((1 << RECIP_SH) + 2) / 3);
    // A multiple of 3 that lifts the signed value into an unsigned range, and its third
    localparam logic [MOFS_W-1:0]  BIAS     = MOFS_W'(3) << (ACC_W - 1);
    localparam logic [WS_W-1:0]    BIAS_Q   = WS_W'(1) << (ACC_W - 1);

    logic signed [ACC_W:0]         n;
    logic signed [ACC_W-1:0]       t;
    logic [MOFS_W-1:0]             mofs_next;
    logic [MOFS_W-1:0]             mofs_reg;
    logic [HI_W-1:0]               hi_next;
    logic [HI_W-1:0]               hi_reg;
    logic [HSUM_W-1:0]             hsum_next;
    logic [HSUM_W-1:0]             hsum_reg;
    logic [PH_W-1:0]               ph_next;
    logic [PH_W-1:0]               ph_reg;
    logic [HSUM_W+RECIP_W-1:0]     qprod;
    logic [Q_W-1:0]                q_next;
    logic [Q_W-1:0]                q_reg;
    logic [WS_W-1:0]               wsum;
    logic signed [WGT_W-1:0]       weight_next;
    logic signed [WGT_W-1:0]       weight_reg;

    always_comb
    begin
        // floor((acc + 3) / 6) = floor(floor((acc + 3) / 2) / 3)
        n         = {acc[ACC_W-1], acc} + (ACC_W + 1)'(3);
        t         = signed'(n[ACC_W:1]);
        mofs_next = MOFS_W'(t) + BIAS;
        // 2^SPLIT = 1 mod 3: fold the high part onto the low part
        hi_next   = mofs_reg[MOFS_W-1:SPLIT];
        hsum_next = HSUM_W'(mofs_reg[MOFS_W-1:SPLIT]) + HSUM_W'(mofs_reg[SPLIT-1:0]);
        ph_next   = hi_reg * THIRD_HI;
        qprod     = hsum_reg * RECIP3;
        q_next    = qprod[RECIP_SH +: Q_W];
        wsum      = WS_W'(ph_reg) + WS_W'(q_reg) - BIAS_Q;
        weight_next = signed'(wsum[WGT_W-1:0]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mofs_reg   <= mofs_next;
            hi_reg     <= hi_next;
            hsum_reg   <= hsum_next;
            ph_reg     <= ph_next;
            q_reg      <= q_next;
            weight_reg <= weight_next;
        end
    end

    assign weight = weight_reg;

endmodule
`default_nettype wire

// ----- rtl/mnc_tap.sv -----
`timescale 1ns / 1ps
`default_nettype none
// One tap of the interpolator: pipelined Horner evaluation of the kernel cubic
// at one distance, then division by 6. Depends on mnc_pkg and mnc_div6.
module mnc_tap #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                             clk,
    input  wire logic                             en,
    input  wire logic [FRACTION_BITS+1:0]         span,
    input  wire mnc_pkg::poly_t                   poly,
    output logic signed [mnc_pkg::WGT_W-1:0]      weight
);
    import mnc_pkg::*;

    localparam int D_W    = FRACTION_BITS + 2;
    localparam int PROD_W = ACC_W + D_W + 1;
    localparam logic [PROD_W-1:0] RND = PROD_W'(1) << (FRACTION_BITS - 1);

    logic signed [D_W:0]        d_in_s;
    logic signed [D_W:0]        d_a1_s;
    logic signed [D_W:0]        d_a2_s;
    logic [D_W-1:0]             d_p1_reg;
    logic [D_W-1:0]             d_a1_reg;
    logic [D_W-1:0]             d_p2_reg;
    logic [D_W-1:0]             d_a2_reg;
    logic signed [PROD_W-1:0]   prod1_next;
    logic signed [PROD_W-1:0]   prod1_reg;
    logic signed [PROD_W-1:0]   prod2_next;
    logic signed [PROD_W-1:0]   prod2_reg;
    logic signed [PROD_W-1:0]   prod3_next;
    logic signed [PROD_W-1:0]   prod3_reg;
    logic signed [ACC_W-1:0]    acc1_next;
    logic signed [ACC_W-1:0]    acc1_reg;
    logic signed [ACC_W-1:0]    acc2_next;
    logic signed [ACC_W-1:0]    acc2_reg;
    logic signed [ACC_W-1:0]    acc3_next;
    logic signed [ACC_W-1:0]    acc3_reg;

    // Drop the fraction bits of a product, rounding half up
    function automatic logic signed [ACC_W-1:0] round_frac(input logic signed [PROD_W-1:0] p);
        logic [PROD_W-1:0] s;
        s = p + RND;
        return signed'(s[FRACTION_BITS +: ACC_W]);
    endfunction

    always_comb
    begin
        d_in_s     = signed'({1'b0, span});
        d_a1_s     = signed'({1'b0, d_a1_reg});
        d_a2_s     = signed'({1'b0, d_a2_reg});
        prod1_next = signed'(poly.c0) * d_in_s;
        acc1_next  = round_frac(prod1_reg) + ACC_W'(signed'(poly.c1));
        prod2_next = acc1_reg * d_a1_s;
        acc2_next  = round_frac(prod2_reg) + ACC_W'(signed'(poly.c2));
        prod3_next = acc2_reg * d_a2_s;
        acc3_next  = round_frac(prod3_reg) + ACC_W'(signed'(poly.c3));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod1_reg <= prod1_next;
            d_p1_reg  <= span;
            acc1_reg  <= acc1_next;
            d_a1_reg  <= d_p1_reg;
            prod2_reg <= prod2_next;
            d_p2_reg  <= d_a1_reg;
            acc2_reg  <= acc2_next;
            d_a2_reg  <= d_p2_reg;
            prod3_reg <= prod3_next;
            acc3_reg  <= acc3_next;
        end
    end

    mnc_div6 u_div6 (
        .clk    (clk),
        .en     (en),
        .acc    (acc3_reg),
        .weight (weight)
    );

endmodule
`default_nettype wire

// ----- rtl/mitchell_netravali_cubic_interp_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Top level of the four-tap Mitchell-Netravali cubic interpolator.
// Depends on mnc_pkg, mnc_coef, mnc_tap (with mnc_div6) and assert_macros.svh.
//
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid/s_axis_tready    four samples and fraction
// m_axis    out        m_axis_tvalid/m_axis_tready    interpolated value, clip flag
// cfg       in         cfg_valid/cfg_ready            register index and data
//
// Throughput is one transaction per cycle on each stream while the output
// buffer has room; a result reaches m_axis through the 13-stage datapath:
// input register, three Horner steps of two stages each
// (multiply, then round and add), four stages of divide-by-6, the sample
// multiplies and the four-way sum. Rounding and saturation sit in front of a
// two-entry output buffer; the pipeline freezes as a whole only when both
// entries are full, so s_axis_tready is registered. Reset clears every valid
// bit and loads B = C = 10923 (about 1/3); cfg_ready is always high.
`include "assert_macros.svh"
module mitchell_netravali_cubic_interp_top #(
    parameter int SAMPLE_BITS   = 16,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // s_axis_tdata fields, low bit up: sample_before, sample_here,
    // sample_next, sample_after, fraction, zero fill to a whole byte
    input  wire logic                                   s_axis_tvalid,
    output logic                                        s_axis_tready,
    input  wire logic [((4*SAMPLE_BITS+FRACTION_BITS+7)/8)*8-1:0] s_axis_tdata,
    // m_axis_tdata fields, low bit up: interpolated, zero fill to a whole byte
    output logic                                        m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]            m_axis_tdata,
    // m_axis_tuser fields: clipped
    output logic                                        m_axis_tuser,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [mnc_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  wire logic [mnc_pkg::SHAPE_W-1:0]            cfg_data
);
    import mnc_pkg::*;

    localparam int OUT_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int D_W         = FRACTION_BITS + 2;
    localparam int MAC_W       = SAMPLE_BITS + WGT_W;
    localparam int SUM_W       = MAC_W + 2;
    localparam int R_W         = SUM_W - HP;
    localparam int SAMP_STAGES = TAP_LAT + 1;
    localparam int NSTG        = TAP_LAT + 3;
    localparam logic [SUM_W-1:0]        HALF_HP = SUM_W'(1) << (HP - 1);
    localparam logic [SAMPLE_BITS-1:0]  OUT_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0]  OUT_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
    localparam logic signed [R_W-1:0]   R_MAX   = R_W'(OUT_MAX);
    localparam logic signed [R_W-1:0]   R_MIN   = -R_MAX - R_W'(1);

    cfg_wr_t                     cfg;
    poly_t                       inner_poly_c;
    poly_t                       outer_poly_c;
    logic                        adv;
    logic [NSTG-1:0]             stage_valid_reg;
    logic signed [SAMPLE_BITS-1:0] in_samp [4];
    logic [FRACTION_BITS-1:0]    in_frac;
    logic [D_W-1:0]              dist_next [4];
    logic [D_W-1:0]              dist_reg [4];
    logic signed [SAMPLE_BITS-1:0] samp_reg [SAMP_STAGES][4];
    logic signed [WGT_W-1:0]     weight [4];
    logic signed [MAC_W-1:0]     prod_reg [4];
    logic signed [SUM_W-1:0]     sum_next;
    logic signed [SUM_W-1:0]     sum_reg;
    logic [SUM_W-1:0]            rnd;
    logic signed [R_W-1:0]       res_r;
    logic [SAMPLE_BITS-1:0]      res_data;
    logic                        res_clip;
    logic                        pop;
    logic                        push;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [SAMPLE_BITS-1:0]      out_data_reg;
    logic [SAMPLE_BITS-1:0]      out_data_next;
    logic                        out_clip_reg;
    logic                        out_clip_next;
    logic                        skid_valid_reg;
    logic                        skid_valid_next;
    logic [SAMPLE_BITS-1:0]      skid_data_reg;
    logic [SAMPLE_BITS-1:0]      skid_data_next;
    logic                        skid_clip_reg;
    logic                        skid_clip_next;

    // Configuration: always ready, decoded in the coefficient block
    assign cfg_ready = 1'b1;
    assign cfg.valid = cfg_valid;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    mnc_coef u_coef (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .inner (inner_poly_c),
        .outer (outer_poly_c)
    );

    // The whole datapath moves together while the output buffer has room
    assign adv           = !skid_valid_reg;
    assign s_axis_tready = adv;

    // Unpack the input transaction and form the four kernel distances (Q2.F)
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            in_samp[i] = signed'(s_axis_tdata[i*SAMPLE_BITS +: SAMPLE_BITS]);
        end
        in_frac      = s_axis_tdata[4*SAMPLE_BITS +: FRACTION_BITS];
        dist_next[0] = {2'b01, in_frac};
        dist_next[1] = {2'b00, in_frac};
        dist_next[2] = (D_W'(1) << FRACTION_BITS) - D_W'(in_frac);
        dist_next[3] = (D_W'(2) << FRACTION_BITS) - D_W'(in_frac);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= '0;
        end
        else if (adv)
        begin
            stage_valid_reg <= {stage_valid_reg[NSTG-2:0], s_axis_tvalid};
        end
    end

    // Hold samples alongside the weight pipeline until the weights are ready
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dist_reg    <= dist_next;
            samp_reg[0] <= in_samp;
            for (int s = 1; s < SAMP_STAGES; s++)
            begin
                samp_reg[s] <= samp_reg[s-1];
            end
        end
    end

    // Outer kernel for the two far samples, inner kernel for the two near ones
    for (genvar i = 0; i < 4; i++)
    begin : g_tap
        mnc_tap #(
            .FRACTION_BITS (FRACTION_BITS)
        ) u_tap (
            .clk    (clk),
            .en     (adv),
            .span   (dist_reg[i]),
            .poly   ((i == 0 || i == 3) ? outer_poly_c : inner_poly_c),
            .weight (weight[i])
        );
    end

    // Weight each sample, then sum exactly
    always_comb
    begin
        sum_next = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1])
                 + SUM_W'(prod_reg[2]) + SUM_W'(prod_reg[3]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
            begin
                prod_reg[i] <= samp_reg[SAMP_STAGES-1][i] * weight[i];
            end
            sum_reg <= sum_next;
        end
    end

    // Round half up out of the internal scale, then saturate
    always_comb
    begin
        rnd   = sum_reg + HALF_HP;
        res_r = signed'(rnd[SUM_W-1:HP]);
        if (res_r > R_MAX)
        begin
            res_data = OUT_MAX;
            res_clip = 1'b1;
        end
        else if (res_r < R_MIN)
        begin
            res_data = OUT_MIN;
            res_clip = 1'b1;
        end
        else
        begin
            res_data = res_r[SAMPLE_BITS-1:0];
            res_clip = 1'b0;
        end
    end

    // Two-entry output buffer: head drives m_axis, skid catches one more result
    assign pop  = out_valid_reg && m_axis_tready;
    assign push = adv && stage_valid_reg[NSTG-1];

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_clip_next   = out_clip_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        skid_clip_next  = skid_clip_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                out_clip_next   = skid_clip_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = res_data;
                out_clip_next  = res_clip;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_data_next  = res_data;
                out_clip_next  = res_clip;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = res_data;
                skid_clip_next  = res_clip;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        out_clip_reg  <= out_clip_next;
        skid_data_reg <= skid_data_next;
        skid_clip_reg <= skid_clip_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(out_data_reg);
    assign m_axis_tuser  = out_clip_reg;

    // Skid entry is only ever filled behind a full head entry
    `ASSERT_IMPLY(a_skid_needs_head, clk, rst_n, skid_valid_reg, out_valid_reg, "skid entry without head entry")
    // A full output buffer freezes the datapath
    `ASSERT_NEXT(a_pipe_frozen, clk, rst_n, skid_valid_reg, $stable(stage_valid_reg), "datapath moved while output buffer full")
    // A clipped result sits at one of the two bounds
    `ASSERT_IMPLY(a_clip_at_bound, clk, rst_n, out_valid_reg && out_clip_reg, (out_data_reg == OUT_MAX) || (out_data_reg == OUT_MIN), "clipped result not at a bound")

endmodule
`default_nettype wire

// ----- sim/mitchell_netravali_cubic_interp_top_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the four-tap cubic interpolator: a directed probe table, then
// random tap sets under several B/C shapes, each result checked against table or predictor.
// Depends on mnc_pkg and mitchell_netravali_cubic_interp_top.
module mitchell_netravali_cubic_interp_top_test;

    import mnc_pkg::*;

    localparam int SMP_W        = 16;
    localparam int FRAC_W       = 16;
    localparam int S_TDATA_W    = ((4 * SMP_W + FRAC_W + 7) / 8) * 8;
    localparam int M_TDATA_W    = ((SMP_W + 7) / 8) * 8;
    localparam int N_PROBES     = 18;
    localparam int N_PHASES     = 9;
    localparam int N_FIXED      = 7;
    localparam int PHASE_ITEMS  = 59;
    localparam int END_SETTLE   = 24;
    localparam int STALL_LIMIT  = 4000;

    // Packed so that sample_before lands in the low bits of tdata
    typedef struct packed {
        logic [FRAC_W-1:0]       fraction;
        logic signed [SMP_W-1:0] sample_after;
        logic signed [SMP_W-1:0] sample_next;
        logic signed [SMP_W-1:0] sample_here;
        logic signed [SMP_W-1:0] sample_before;
    } taps_t;

    typedef struct packed {
        logic                    clipped;
        logic signed [SMP_W-1:0] value;
    } interp_t;

    typedef struct {
        logic [SMP_W-1:0]  s_before;
        logic [SMP_W-1:0]  s_here;
        logic [SMP_W-1:0]  s_next;
        logic [SMP_W-1:0]  s_after;
        logic [FRAC_W-1:0] fraction;
        bit                known;
        logic [SMP_W-1:0]  want_value;
        bit                want_clip;
    } probe_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [SHAPE_W-1:0]     cfg_data = '0;

    // Shadow of the shape registers as the block should hold them
    logic [SHAPE_W-1:0]     shape_b_q = SHAPE_W'(SHAPE_RESET);
    logic [SHAPE_W-1:0]     shape_c_q = SHAPE_W'(SHAPE_RESET);

    interp_t                interp_results_q [$];
    int                     mismatches = 0;
    int                     idle_cycles = 0;
    int                     sent_count = 0;
    bit                     send_burst = 1'b0;

    // Columns: before, here, next, after, fraction, known, value, clip.
    // Known rows all run under the reset shape (B = C = 1/3), where the outer
    // weights at half-way are negative, so opposite-signed rails overshoot.
    probe_row_t probe_rows [N_PROBES] = '{
        '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h0000, 1'b0},
        '{16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 1'b1, 16'h7fff, 1'b1},
        '{16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 1'b1, 16'h8000, 1'b1},
        '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hffff, 1'b0, 16'h0000, 1'b0},
        '{16'h0000, 16'h7fff, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{16'h0000, 16'h0000, 16'h7fff, 16'h0000, 16'hffff, 1'b0, 16'h0000, 1'b0},
        '{16'h0000, 16'h0000, 16'h0000, 16'h7fff, 16'h0001, 1'b0, 16'h0000, 1'b0},
        '{16'h7fff, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 1'b0, 16'h0000, 1'b0},
        '{16'h0100, 16'h0200, 16'h0300, 16'h0400, 16'h4000, 1'b0, 16'h0000, 1'b0},
        '{16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hc000, 1'b0, 16'h0000, 1'b0},
        '{16'h0001, 16'hffff, 16'h0001, 16'hffff, 16'h0001, 1'b0, 16'h0000, 1'b0},
        '{16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'haaaa, 1'b0, 16'h0000, 1'b0},
        '{16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'h5555, 1'b0, 16'h0000, 1'b0},
        '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff, 1'b0, 16'h0000, 1'b0},
        '{16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'hffff, 1'b0, 16'h0000, 1'b0}
    };

    // Fixed shape settings: both extremes, values above 1.0 (clamped), mixes
    logic [SHAPE_W-1:0] fixed_b [N_FIXED] = '{16'd0, 16'd32768, 16'hffff, 16'd0,
                                              16'd32768, 16'd40000, 16'd10923};
    logic [SHAPE_W-1:0] fixed_c [N_FIXED] = '{16'd0, 16'd32768, 16'hffff, 16'd32768,
                                              16'd0, 16'd12345, 16'd10923};

    mitchell_netravali_cubic_interp_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    // Arithmetic shift right with rounding half toward plus infinity
    function automatic longint round_shr(input longint v, input int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint div6_round(input longint v);
        longint n;
        longint q;
        n = v + 3;
        q = n / 6;
        if (n % 6 != 0 && n < 0)
            q = q - 1;
        return q;
    endfunction

    // Kernel for |x| < 1, Horner form; x^1 term is zero
    function automatic longint kernel_near(input longint k [3], input longint d);
        longint acc;
        acc = k[0];
        acc = round_shr(acc * d, FRAC_W) + k[1];
        acc = round_shr(acc * d, FRAC_W);
        acc = round_shr(acc * d, FRAC_W) + k[2];
        return div6_round(acc);
    endfunction

    // Kernel for 1 <= |x| <= 2
    function automatic longint kernel_far(input longint l [4], input longint d);
        longint acc;
        acc = l[0];
        acc = round_shr(acc * d, FRAC_W) + l[1];
        acc = round_shr(acc * d, FRAC_W) + l[2];
        acc = round_shr(acc * d, FRAC_W) + l[3];
        return div6_round(acc);
    endfunction

    function automatic interp_t mn_interpolate(input logic [SHAPE_W-1:0] b_reg,
                                               input logic [SHAPE_W-1:0] c_reg,
                                               input taps_t t);
        longint b;
        longint c;
        longint one;
        longint up;
        longint a;
        longint f1;
        longint acc_sum;
        longint r;
        longint hi;
        longint lo;
        longint near_coef [3];
        longint far_coef [4];
        interp_t res;
        b   = (b_reg > SHAPE_ONE) ? longint'(SHAPE_ONE) : longint'(b_reg);
        c   = (c_reg > SHAPE_ONE) ? longint'(SHAPE_ONE) : longint'(c_reg);
        one = longint'(SHAPE_ONE);
        up  = longint'(1) <<< UP_SH;
        near_coef[0] = (K3_ONE * one - K3_B * b - K3_C * c) * up;
        near_coef[1] = (K2_ONE * one + K2_B * b + K2_C * c) * up;
        near_coef[2] = (K0_ONE * one - K0_B * b) * up;
        far_coef[0]  = (-(L3_B * b) - L3_C * c) * up;
        far_coef[1]  = (L2_B * b + L2_C * c) * up;
        far_coef[2]  = (-(L1_B * b) - L1_C * c) * up;
        far_coef[3]  = (L0_B * b + L0_C * c) * up;
        a  = longint'(t.fraction);
        f1 = longint'(1) <<< FRAC_W;
        acc_sum = longint'(t.sample_before) * kernel_far(far_coef, f1 + a)
                + longint'(t.sample_here)   * kernel_near(near_coef, a)
                + longint'(t.sample_next)   * kernel_near(near_coef, f1 - a)
                + longint'(t.sample_after)  * kernel_far(far_coef, 2 * f1 - a);
        r  = round_shr(acc_sum, HP);
        hi = (longint'(1) <<< (SMP_W - 1)) - 1;
        lo = -hi - 1;
        res.clipped = 1'b0;
        if (r > hi)
        begin
            r = hi;
            res.clipped = 1'b1;
        end
        else if (r < lo)
        begin
            r = lo;
            res.clipped = 1'b1;
        end
        res.value = SMP_W'(r);
        return res;
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic taps_t draw_taps();
        logic [SMP_W-1:0]  rails [5] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001};
        logic [FRAC_W-1:0] edges [5] = '{16'h0000, 16'h0001, 16'h8000, 16'hfffe, 16'hffff};
        logic [SMP_W-1:0]  s [4];
        int                kind;
        int                base;
        int                slope;
        bit                flip;
        taps_t             t;
        kind = $urandom_range(0, 19);
        if (kind < 10)
        begin
            // smooth run: a ramp through the four taps plus a little noise
            base  = $urandom_range(0, 65535) - 32768;
            slope = $urandom_range(0, 8191) - 4096;
            for (int i = 0; i < 4; i++)
                s[i] = SMP_W'(base + i * slope + $urandom_range(0, 63) - 32);
        end
        else if (kind < 15)
        begin
            for (int i = 0; i < 4; i++)
                s[i] = SMP_W'($urandom);
        end
        else if (kind < 18)
        begin
            for (int i = 0; i < 4; i++)
                s[i] = rails[$urandom_range(0, 4)];
        end
        else
        begin
            // inner taps near one rail, outer near the other: drives overshoot
            flip = 1'($urandom_range(0, 1));
            for (int i = 0; i < 4; i++)
                s[i] = (((i == 1) || (i == 2)) ^ flip) ? 16'h7fff - SMP_W'($urandom_range(0, 255))
                                                     : 16'h8000 + SMP_W'($urandom_range(0, 255));
        end
        t.sample_before = s[0];
        t.sample_here   = s[1];
        t.sample_next   = s[2];
        t.sample_after  = s[3];
        t.fraction      = ($urandom_range(0, 4) == 0) ? edges[$urandom_range(0, 4)]
                                                      : FRAC_W'($urandom);
        return t;
    endfunction

    // Present one tap set; valid stays high when the next one follows at once
    task automatic send_taps(input taps_t t, input bit known, input interp_t want);
        int gap;
        if (sent_count % 40 == 0)
            send_burst = ($urandom_range(0, 2) == 0);
        gap = send_burst ? 0 : $urandom_range(0, 8);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata  <= t;
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        sent_count++;
        interp_results_q.push_back(known ? want : mn_interpolate(shape_b_q, shape_c_q, t));
    endtask

    // Drop valid and hold off until every outstanding result is back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (interp_results_q.size() != 0);
    endtask

    // Caller drops cfg_valid after the last write of a group
    task automatic write_shape(input logic [CFG_INDEX_W-1:0] idx, input logic [SHAPE_W-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_SHAPE_B)
            shape_b_q = value;
        else if (idx == REG_SHAPE_C)
            shape_c_q = value;
    endtask

    initial
    begin : stimulus
        taps_t             t;
        interp_t           want;
        logic [SHAPE_W-1:0] b_val;
        logic [SHAPE_W-1:0] c_val;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Probe table under the reset shape
        foreach (probe_rows[i])
        begin
            t.sample_before = probe_rows[i].s_before;
            t.sample_here   = probe_rows[i].s_here;
            t.sample_next   = probe_rows[i].s_next;
            t.sample_after  = probe_rows[i].s_after;
            t.fraction      = probe_rows[i].fraction;
            want.value      = probe_rows[i].want_value;
            want.clipped    = probe_rows[i].want_clip;
            send_taps(t, probe_rows[i].known, want);
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            drain_results();
            if (p < N_FIXED)
            begin
                b_val = fixed_b[p];
                c_val = fixed_c[p];
            end
            else
            begin
                b_val = SHAPE_W'($urandom_range(0, SHAPE_ONE));
                c_val = SHAPE_W'($urandom_range(0, SHAPE_ONE));
            end
            write_shape(REG_SHAPE_B, b_val);
            write_shape(REG_SHAPE_C, c_val);
            // unmapped index: must leave both shapes alone
            write_shape(CFG_INDEX_W'($urandom_range(REG_SHAPE_C + 1, 2 ** CFG_INDEX_W - 1)),
                        SHAPE_W'($urandom));
            cfg_valid <= 1'b0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 63) == 0)
                    drain_results();
                send_taps(draw_taps(), 1'b0, '0);
            end
        end

        drain_results();
        repeat (END_SETTLE) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // ---------------------------------------------------------------- checking

    initial
    begin : result_sink
        int      stall;
        int      taken;
        bit      sink_burst;
        interp_t got;
        interp_t want;
        taken      = 0;
        sink_burst = 1'b0;
        forever
        begin
            if (taken % 40 == 0)
                sink_burst = ($urandom_range(0, 2) == 0);
            stall = sink_burst ? 0 : $urandom_range(0, 8);
            if (stall != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
            taken++;
            got.value   = m_axis_tdata[SMP_W-1:0];
            got.clipped = m_axis_tuser;
            if (interp_results_q.size() == 0)
            begin
                $display("%0t: unexpected result value %0d clip %0b", $time, got.value,
                         got.clipped);
                mismatches++;
            end
            else
            begin
                want = interp_results_q.pop_front();
                if (got.value !== want.value)
                begin
                    $display("%0t: interpolated expected %0d, got %0d", $time, want.value,
                             got.value);
                    mismatches++;
                end
                if (got.clipped !== want.clipped)
                begin
                    $display("%0t: clipped expected %0b, got %0b", $time, want.clipped,
                             got.clipped);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: end the run when no channel moves a transaction for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == STALL_LIMIT)
        begin
            $display("%0t: watchdog expired with %0d results outstanding", $time,
                     interp_results_q.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule
